// ===== hdl/tlh_pkg.sv =====
// tlh_pkg: shared codes, constants and controller/datapath interface structs
// for the transaction latency histogram; no dependencies
package tlh_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_TX   = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // result status codes
    localparam logic [2:0] ST_RECORDED  = 3'd0;
    localparam logic [2:0] ST_FILTERED  = 3'd1;
    localparam logic [2:0] ST_NO_MATCH  = 3'd2;
    localparam logic [2:0] ST_NEGATIVE  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_READ_OK   = 3'd5;
    localparam logic [2:0] ST_READ_MISS = 3'd6;

    // configuration register indexes
    localparam logic [0:0] REG_MS_MODE = 1'b0;
    localparam logic [0:0] REG_FILTER  = 1'b1;

    // tlv types in bits 15..11 of a type-length word
    localparam logic [4:0] TLV_STRING  = 5'd2;
    localparam logic [4:0] TLV_LATENCY = 5'd4;

    localparam logic [6:0] METHOD_WRITE = 7'h02;

    // reciprocal scaling: us = ((x >> 3) * US_MAGIC) >> 68,
    // ms = ((x >> 6) * MS_MAGIC) >> 75, exact for operands below 2^61
    localparam logic [63:0] US_MAGIC = 64'(((128'd1 << 68) + 128'd124) / 128'd125);
    localparam logic [63:0] MS_MAGIC = 64'(((128'd1 << 75) + 128'd15624) / 128'd15625);

    // read-modify-write targets
    localparam logic [2:0] RMW_E2E_BIN = 3'd0;
    localparam logic [2:0] RMW_E2E_SUM = 3'd1;
    localparam logic [2:0] RMW_E2E_CNT = 3'd2;
    localparam logic [2:0] RMW_FW_BIN  = 3'd3;
    localparam logic [2:0] RMW_FW_SUM  = 3'd4;
    localparam logic [2:0] RMW_FW_CNT  = 3'd5;

    // word offsets of a key's sum/count row
    localparam logic [1:0] OFF_E2E_SUM = 2'd0;
    localparam logic [1:0] OFF_E2E_CNT = 2'd1;
    localparam logic [1:0] OFF_FW_SUM  = 2'd2;
    localparam logic [1:0] OFF_FW_CNT  = 2'd3;

    localparam logic LOG_E2E = 1'b0;
    localparam logic LOG_FW  = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       p_scan;
        logic       p_write;
        logic       p_free;
        logic       k_scan;
        logic       k_alloc;
        logic       clr_step;
        logic       div_start;
        logic       log_start;
        logic       log_save;
        logic       log_sel;
        logic       rmw_rd;
        logic       rmw_wr;
        logic [2:0] rmw_sel;
        logic       rd_issue;
        logic       rd_capture;
        logic       load_out;
        logic [2:0] out_status;
    } tlh_cmd_t;

    typedef struct packed {
        logic [1:0] cmd_code;
        logic       filtered;
        logic       p_done;
        logic       p_hit;
        logic       p_free_ok;
        logic       delta_neg;
        logic       k_done;
        logic       k_hit;
        logic       k_free_ok;
        logic       idx_ok;
        logic       clr_done;
        logic       div_done;
        logic       log_done;
        logic       has_lat;
        logic       out_busy;
    } tlh_sts_t;

endpackage

// ===== hdl/tlh_div.sv =====
// tlh_div: scales a 64-bit delta to us or ms by reciprocal multiplication,
// four 32x32 partial products accumulated in turn; depends on tlh_pkg
module tlh_div
    import tlh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        ms,
    input  logic [63:0] dividend,
    output logic [63:0] quotient,
    output logic        done
);

    logic [63:0]  y_reg, y_next;
    logic [63:0]  m_reg, m_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   step_reg, step_next;
    logic         ms_reg, ms_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  op_a, op_b;
    logic [63:0]  prod;
    logic [127:0] term;

    always_comb
    begin
        op_a = step_reg[0] ? y_reg[63:32] : y_reg[31:0];
        op_b = step_reg[1] ? m_reg[63:32] : m_reg[31:0];
        prod = {32'b0, op_a} * {32'b0, op_b};
        unique case (step_reg)
            2'd0:       term = {64'b0, prod};
            2'd1, 2'd2: term = {32'b0, prod, 32'b0};
            default:    term = {prod, 64'b0};
        endcase
        y_next    = y_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        ms_next   = ms_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            y_next    = ms ? {6'b0, dividend[63:6]} : {3'b0, dividend[63:3]};
            m_next    = ms ? MS_MAGIC : US_MAGIC;
            acc_next  = '0;
            step_next = '0;
            ms_next   = ms;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + term;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        ms_reg  <= ms_next;
    end

    assign quotient = ms_reg ? {11'b0, acc_reg[127:75]} : {4'b0, acc_reg[127:68]};
    assign done     = done_reg;

endmodule

// ===== hdl/tlh_log2.sv =====
// tlh_log2: floor-log2 bucket of a 64-bit value capped at SLOTS-1,
// one shift per cycle; depends on tlh_pkg
module tlh_log2
    import tlh_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [63:0]              value,
    output logic [$clog2(SLOTS)-1:0] bucket,
    output logic                     done
);

    localparam int LW = $clog2(SLOTS);

    logic [63:0]   v_reg, v_next;
    logic [LW-1:0] b_reg, b_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    always_comb
    begin
        v_next    = v_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            v_next    = value;
            b_next    = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if ((|v_reg[63:1]) && (b_reg != LW'(SLOTS - 1)))
            begin
                v_next = {1'b0, v_reg[63:1]};
                b_next = b_reg + LW'(1);
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        b_reg <= b_next;
    end

    assign bucket = b_reg;
    assign done   = done_reg;

endmodule

// ===== hdl/tlh_dp.sv =====
// tlh_dp: datapath with pending and key tables, histogram memories,
// divider, log2 unit and result register; depends on tlh_pkg, tlh_div, tlh_log2
module tlh_dp
    import tlh_pkg::*;
#(
    parameter int PENDING_DEPTH = 256,
    parameter int HIST_KEYS     = 16,
    parameter int SLOTS         = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [255:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,
    output logic [2:0]   m_tuser,
    input  tlh_cmd_t     cmd,
    output tlh_sts_t     sts
);

    localparam int PW      = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int KW      = (HIST_KEYS > 1) ? $clog2(HIST_KEYS) : 1;
    localparam int LW      = $clog2(SLOTS);
    localparam int CLR_LEN = (SLOTS > 4) ? SLOTS : 4;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int BDEPTH  = HIST_KEYS * SLOTS;
    localparam int BW      = $clog2(BDEPTH);
    localparam int SW      = KW + 2;

    // configuration
    logic        ms_mode_reg;
    logic [15:0] reg_filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_mode_reg    <= 1'b0;
            reg_filter_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MS_MODE: ms_mode_reg    <= cfg_wdata[0];
                REG_FILTER:  reg_filter_reg <= cfg_wdata;
                default:     ms_mode_reg    <= ms_mode_reg;
            endcase
        end
    end

    // captured transaction
    logic [1:0]  cmd_reg;
    logic [63:0] time_reg, tid_reg;
    logic [15:0] reg_id_reg, tl1_reg, tl2_reg;
    logic [7:0]  method_reg;
    logic [31:0] lat1_reg, lat2_reg;
    logic        hsel_reg;
    logic [5:0]  ridx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg    <= s_tuser[1:0];
            hsel_reg   <= s_tuser[2];
            time_reg   <= s_tdata[63:0];
            tid_reg    <= s_tdata[127:64];
            reg_id_reg <= s_tdata[143:128];
            method_reg <= s_tdata[151:144];
            tl1_reg    <= s_tdata[167:152];
            tl2_reg    <= s_tdata[183:168];
            lat1_reg   <= s_tdata[215:184];
            lat2_reg   <= s_tdata[247:216];
            ridx_reg   <= s_tdata[253:248];
        end
    end

    logic        filtered;
    logic [16:0] key_val;
    logic        has_lat;
    logic [31:0] lat;
    logic        ridx_bin;

    always_comb
    begin
        filtered = (reg_filter_reg != '0) && (reg_id_reg != reg_filter_reg);
        key_val  = {reg_id_reg, (method_reg[6:0] == METHOD_WRITE)};
        has_lat  = 1'b0;
        lat      = '0;
        if (tl1_reg[15:11] == TLV_STRING)
        begin
            if (tl2_reg[15:11] == TLV_LATENCY)
            begin
                has_lat = 1'b1;
                lat     = lat2_reg;
            end
        end
        else if (tl1_reg[15:11] == TLV_LATENCY)
        begin
            has_lat = 1'b1;
            lat     = lat1_reg;
        end
        ridx_bin = {1'b0, ridx_reg} < 7'(SLOTS);
    end

    // pending table: valid bits in flops, tid/time in memory, scanned one per cycle
    logic [PENDING_DEPTH-1:0] pv_reg;
    logic [63:0]              ptid_mem [PENDING_DEPTH];
    logic [63:0]              ptime_mem [PENDING_DEPTH];
    logic [63:0]              ptid_q, ptime_q;
    logic [PW-1:0]            p_cnt_reg, p_stg_idx_reg, p_hidx_reg, p_fidx_reg, p_widx;
    logic                     p_stg_vld_reg, p_stg_last_reg, p_hit_reg, p_free_reg;
    logic [63:0]              p_htime_reg;
    logic                     p_match, p_empty;

    assign p_match = p_stg_vld_reg && pv_reg[p_stg_idx_reg] && (ptid_q == tid_reg);
    assign p_empty = p_stg_vld_reg && !pv_reg[p_stg_idx_reg];
    assign p_widx  = p_hit_reg ? p_hidx_reg : p_fidx_reg;

    always_ff @(posedge clk)
    begin
        ptid_q  <= ptid_mem[p_cnt_reg];
        ptime_q <= ptime_mem[p_cnt_reg];
        if (cmd.p_write)
        begin
            ptid_mem[p_widx]  <= tid_reg;
            ptime_mem[p_widx] <= time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg         <= '0;
            p_cnt_reg      <= '0;
            p_stg_vld_reg  <= 1'b0;
            p_stg_last_reg <= 1'b0;
            p_hit_reg      <= 1'b0;
            p_free_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                p_cnt_reg     <= '0;
                p_stg_vld_reg <= 1'b0;
                p_hit_reg     <= 1'b0;
                p_free_reg    <= 1'b0;
            end
            else if (cmd.p_scan)
            begin
                p_stg_vld_reg  <= 1'b1;
                p_stg_last_reg <= (p_cnt_reg == PW'(PENDING_DEPTH - 1));
                if (p_cnt_reg != PW'(PENDING_DEPTH - 1))
                    p_cnt_reg <= p_cnt_reg + PW'(1);
                if (p_match && !p_hit_reg)
                    p_hit_reg <= 1'b1;
                if (p_empty && !p_free_reg)
                    p_free_reg <= 1'b1;
            end
            if (cmd.p_write)
                pv_reg[p_widx] <= 1'b1;
            if (cmd.p_free)
                pv_reg[p_hidx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_scan)
        begin
            p_stg_idx_reg <= p_cnt_reg;
            if (p_match && !p_hit_reg)
            begin
                p_hidx_reg  <= p_stg_idx_reg;
                p_htime_reg <= ptime_q;
            end
            if (p_empty && !p_free_reg)
                p_fidx_reg <= p_stg_idx_reg;
        end
    end

    logic [63:0] delta;
    assign delta = time_reg - p_htime_reg;

    // key table
    logic [HIST_KEYS-1:0] kv_reg;
    logic [16:0]          key_mem [HIST_KEYS];
    logic [16:0]          k_q;
    logic [KW-1:0]        k_cnt_reg, k_stg_idx_reg, k_idx_reg, k_fidx_reg;
    logic                 k_stg_vld_reg, k_stg_last_reg, k_hit_reg, k_free_reg;
    logic                 k_match, k_empty;

    assign k_match = k_stg_vld_reg && kv_reg[k_stg_idx_reg] && (k_q == key_val);
    assign k_empty = k_stg_vld_reg && !kv_reg[k_stg_idx_reg];

    always_ff @(posedge clk)
    begin
        k_q <= key_mem[k_cnt_reg];
        if (cmd.k_alloc)
            key_mem[k_fidx_reg] <= key_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kv_reg         <= '0;
            k_cnt_reg      <= '0;
            k_stg_vld_reg  <= 1'b0;
            k_stg_last_reg <= 1'b0;
            k_hit_reg      <= 1'b0;
            k_free_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                k_cnt_reg     <= '0;
                k_stg_vld_reg <= 1'b0;
                k_hit_reg     <= 1'b0;
                k_free_reg    <= 1'b0;
            end
            else if (cmd.k_scan)
            begin
                k_stg_vld_reg  <= 1'b1;
                k_stg_last_reg <= (k_cnt_reg == KW'(HIST_KEYS - 1));
                if (k_cnt_reg != KW'(HIST_KEYS - 1))
                    k_cnt_reg <= k_cnt_reg + KW'(1);
                if (k_match && !k_hit_reg)
                    k_hit_reg <= 1'b1;
                if (k_empty && !k_free_reg)
                    k_free_reg <= 1'b1;
            end
            if (cmd.k_alloc)
                kv_reg[k_fidx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.k_scan)
        begin
            k_stg_idx_reg <= k_cnt_reg;
            if (k_match && !k_hit_reg)
                k_idx_reg <= k_stg_idx_reg;
            if (k_empty && !k_free_reg)
                k_fidx_reg <= k_stg_idx_reg;
        end
        if (cmd.k_alloc)
            k_idx_reg <= k_fidx_reg;
    end

    // arithmetic units
    logic [63:0]   quot;
    logic          div_done, log_done;
    logic [LW-1:0] log_b, e2e_b_reg, fw_b_reg;

    tlh_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .ms       (ms_mode_reg),
        .dividend (delta),
        .quotient (quot),
        .done     (div_done)
    );

    tlh_log2 #(.SLOTS(SLOTS)) u_log2
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .value  ((cmd.log_sel == LOG_FW) ? {32'b0, lat} : quot),
        .bucket (log_b),
        .done   (log_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.log_save)
        begin
            if (cmd.log_sel == LOG_FW)
                fw_b_reg <= log_b;
            else
                e2e_b_reg <= log_b;
        end
    end

    // histogram memories
    logic [CW-1:0] clr_cnt_reg;
    logic          clr_done, clr_bin, clr_sum;
    logic [31:0]   e2e_mem [BDEPTH];
    logic [31:0]   fw_mem [BDEPTH];
    logic [63:0]   sum_mem [HIST_KEYS * 4];
    logic [31:0]   e2e_q, fw_q;
    logic [63:0]   sum_q, addend;
    logic [LW-1:0] bin_idx;
    logic [1:0]    sum_off;
    logic [BW-1:0] bin_addr;
    logic [SW-1:0] sum_addr;
    logic          rmw_any, sum_sel;

    assign clr_done = (clr_cnt_reg == CW'(CLR_LEN - 1));
    assign clr_bin  = {1'b0, clr_cnt_reg} < (CW + 1)'(SLOTS);
    assign clr_sum  = {1'b0, clr_cnt_reg} < (CW + 1)'(4);
    assign rmw_any  = cmd.rmw_rd || cmd.rmw_wr;
    assign sum_sel  = (cmd.rmw_sel == RMW_E2E_SUM) || (cmd.rmw_sel == RMW_E2E_CNT)
                   || (cmd.rmw_sel == RMW_FW_SUM) || (cmd.rmw_sel == RMW_FW_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.k_alloc)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step && !clr_done)
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
    end

    always_comb
    begin
        if (cmd.clr_step)
        begin
            bin_idx = clr_cnt_reg[LW-1:0];
            sum_off = clr_cnt_reg[1:0];
        end
        else if (rmw_any)
        begin
            bin_idx = (cmd.rmw_sel == RMW_FW_BIN) ? fw_b_reg : e2e_b_reg;
            unique case (cmd.rmw_sel)
                RMW_E2E_CNT: sum_off = OFF_E2E_CNT;
                RMW_FW_SUM:  sum_off = OFF_FW_SUM;
                RMW_FW_CNT:  sum_off = OFF_FW_CNT;
                default:     sum_off = OFF_E2E_SUM;
            endcase
        end
        else
        begin
            bin_idx = ridx_reg[LW-1:0];
            sum_off = {hsel_reg, ({1'b0, ridx_reg} != 7'(SLOTS))};
        end
        bin_addr = BW'(BW'(k_idx_reg) * BW'(SLOTS)) + BW'(bin_idx);
        sum_addr = {k_idx_reg, sum_off};
        unique case (cmd.rmw_sel)
            RMW_E2E_SUM: addend = quot;
            RMW_FW_SUM:  addend = {32'b0, lat};
            default:     addend = 64'd1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        e2e_q <= e2e_mem[bin_addr];
        fw_q  <= fw_mem[bin_addr];
        sum_q <= sum_mem[sum_addr];
        if (cmd.clr_step && clr_bin)
        begin
            e2e_mem[bin_addr] <= '0;
            fw_mem[bin_addr]  <= '0;
        end
        else if (cmd.rmw_wr && (cmd.rmw_sel == RMW_E2E_BIN))
            e2e_mem[bin_addr] <= e2e_q + 32'd1;
        else if (cmd.rmw_wr && (cmd.rmw_sel == RMW_FW_BIN))
            fw_mem[bin_addr] <= fw_q + 32'd1;
        if (cmd.clr_step && clr_sum)
            sum_mem[sum_addr] <= '0;
        else if (cmd.rmw_wr && sum_sel)
            sum_mem[sum_addr] <= sum_q + addend;
    end

    // read value and result register
    logic [63:0] rd_val_reg;
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [4:0]  out_e2e_reg, out_fwb_reg;
    logic        out_fwrec_reg;
    logic [63:0] out_val_reg;
    logic        recorded;

    // buckets only go out for a receive that updated the histogram
    assign recorded = (cmd.out_status == ST_RECORDED) && (cmd_reg == CMD_RX);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_val_reg <= '0;
        else if (cmd.rd_capture)
            rd_val_reg <= ridx_bin ? {32'b0, (hsel_reg ? fw_q : e2e_q)} : sum_q;
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_e2e_reg    <= recorded ? 5'(e2e_b_reg) : 5'd0;
            out_fwrec_reg  <= recorded && has_lat;
            out_fwb_reg    <= (recorded && has_lat) ? 5'(fw_b_reg) : 5'd0;
            out_val_reg    <= (cmd.out_status == ST_READ_OK) ? rd_val_reg : 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'b0, out_val_reg, out_fwb_reg, out_fwrec_reg, out_e2e_reg};

    always_comb
    begin
        sts.cmd_code  = cmd_reg;
        sts.filtered  = filtered;
        sts.p_done    = p_stg_vld_reg && (p_stg_last_reg || p_match);
        sts.p_hit     = p_hit_reg;
        sts.p_free_ok = p_free_reg;
        sts.delta_neg = delta[63];
        sts.k_done    = k_stg_vld_reg && (k_stg_last_reg || k_match);
        sts.k_hit     = k_hit_reg;
        sts.k_free_ok = k_free_reg;
        sts.idx_ok    = {1'b0, ridx_reg} < 7'(SLOTS + 2);
        sts.clr_done  = clr_done;
        sts.div_done  = div_done;
        sts.log_done  = log_done;
        sts.has_lat   = has_lat;
        sts.out_busy  = out_valid_reg && !m_tready;
    end

endmodule

// ===== hdl/tlh_ctrl.sv =====
// tlh_ctrl: sequencing state machine for the latency histogram,
// drives tlh_dp through tlh_cmd_t; depends on tlh_pkg
module tlh_ctrl
    import tlh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  tlh_sts_t sts,
    output tlh_cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_PSCAN    = 4'd2;
    localparam logic [3:0] S_PDEC     = 4'd3;
    localparam logic [3:0] S_KSCAN    = 4'd4;
    localparam logic [3:0] S_KDEC     = 4'd5;
    localparam logic [3:0] S_CLR      = 4'd6;
    localparam logic [3:0] S_DIV_GO   = 4'd7;
    localparam logic [3:0] S_DIV_WAIT = 4'd8;
    localparam logic [3:0] S_LOG_GO   = 4'd9;
    localparam logic [3:0] S_LOG_WAIT = 4'd10;
    localparam logic [3:0] S_RMW_RD   = 4'd11;
    localparam logic [3:0] S_RMW_WR   = 4'd12;
    localparam logic [3:0] S_RD_ISSUE = 4'd13;
    localparam logic [3:0] S_RD_DATA  = 4'd14;
    localparam logic [3:0] S_FIN      = 4'd15;

    logic [3:0] state_reg, state_next;
    logic [2:0] status_reg, status_next;
    logic [2:0] rmw_sel_reg, rmw_sel_next;
    logic       log_sel_reg, log_sel_next;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        rmw_sel_next   = rmw_sel_reg;
        log_sel_next   = log_sel_reg;
        cmd            = '0;
        cmd.log_sel    = log_sel_reg;
        cmd.rmw_sel    = rmw_sel_reg;
        cmd.out_status = status_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd_code)
                    CMD_TX, CMD_RX:
                    begin
                        if (sts.filtered)
                        begin
                            status_next = ST_FILTERED;
                            state_next  = S_FIN;
                        end
                        else
                            state_next = S_PSCAN;
                    end
                    CMD_READ: state_next = S_KSCAN;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_PSCAN:
            begin
                cmd.p_scan = 1'b1;
                if (sts.p_done)
                    state_next = S_PDEC;
            end
            S_PDEC:
            begin
                state_next = S_FIN;
                if (sts.cmd_code == CMD_TX)
                begin
                    if (sts.p_hit || sts.p_free_ok)
                    begin
                        cmd.p_write = 1'b1;
                        status_next = ST_RECORDED;
                    end
                    else
                        status_next = ST_FULL;
                end
                else if (!sts.p_hit)
                    status_next = ST_NO_MATCH;
                else
                begin
                    cmd.p_free = 1'b1;
                    if (sts.delta_neg)
                        status_next = ST_NEGATIVE;
                    else
                        state_next = S_KSCAN;
                end
            end
            S_KSCAN:
            begin
                cmd.k_scan = 1'b1;
                if (sts.k_done)
                    state_next = S_KDEC;
            end
            S_KDEC:
            begin
                if (sts.cmd_code == CMD_READ)
                begin
                    if (sts.k_hit && sts.idx_ok)
                        state_next = S_RD_ISSUE;
                    else
                    begin
                        status_next = ST_READ_MISS;
                        state_next  = S_FIN;
                    end
                end
                else if (sts.k_hit)
                    state_next = S_DIV_GO;
                else if (sts.k_free_ok)
                begin
                    cmd.k_alloc = 1'b1;
                    state_next  = S_CLR;
                end
                else
                begin
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    log_sel_next = LOG_E2E;
                    state_next   = S_LOG_GO;
                end
            end
            S_LOG_GO:
            begin
                cmd.log_start = 1'b1;
                state_next    = S_LOG_WAIT;
            end
            S_LOG_WAIT:
            begin
                if (sts.log_done)
                begin
                    cmd.log_save = 1'b1;
                    if ((log_sel_reg == LOG_E2E) && sts.has_lat)
                    begin
                        log_sel_next = LOG_FW;
                        state_next   = S_LOG_GO;
                    end
                    else
                    begin
                        rmw_sel_next = RMW_E2E_BIN;
                        state_next   = S_RMW_RD;
                    end
                end
            end
            S_RMW_RD:
            begin
                cmd.rmw_rd = 1'b1;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = S_RMW_RD;
                unique case (rmw_sel_reg)
                    RMW_E2E_BIN: rmw_sel_next = RMW_E2E_SUM;
                    RMW_E2E_SUM: rmw_sel_next = RMW_E2E_CNT;
                    RMW_E2E_CNT:
                    begin
                        if (sts.has_lat)
                            rmw_sel_next = RMW_FW_BIN;
                        else
                        begin
                            status_next = ST_RECORDED;
                            state_next  = S_FIN;
                        end
                    end
                    RMW_FW_BIN:  rmw_sel_next = RMW_FW_SUM;
                    RMW_FW_SUM:  rmw_sel_next = RMW_FW_CNT;
                    default:
                    begin
                        status_next = ST_RECORDED;
                        state_next  = S_FIN;
                    end
                endcase
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                cmd.rd_capture = 1'b1;
                status_next    = ST_READ_OK;
                state_next     = S_FIN;
            end
            default:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_RECORDED;
            rmw_sel_reg <= RMW_E2E_BIN;
            log_sel_reg <= LOG_E2E;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            rmw_sel_reg <= rmw_sel_next;
            log_sel_reg <= log_sel_next;
        end
    end

    // result register is only reloaded once the previous result has left
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("result register overwritten while occupied");

    // every memory write of a read-modify-write follows its read
    a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rmw_wr |-> $past(cmd.rmw_rd))
        else $error("rmw write without preceding read");

    // table and memory operations never overlap
    a_ops_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.p_scan, cmd.k_scan, cmd.clr_step, cmd.rmw_rd, cmd.rmw_wr,
                  cmd.rd_issue, cmd.p_write, cmd.k_alloc}))
        else $error("overlapping datapath operations");

    // a free of a pending entry only happens on a receive that found it
    a_free_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.p_free |-> (sts.p_hit && (sts.cmd_code == CMD_RX)))
        else $error("pending entry freed without a match");

endmodule

// ===== hdl/transaction_latency_histogram.sv =====
// transaction_latency_histogram: top level, config port, controller and datapath
// sequence from acceptance to result valid: transmit runs a linear pending table scan;
//   receive runs the scans, bin clear on a new key, 4-step reciprocal multiply,
//   up to two log2 passes and up to six rmw steps
// flow: one transaction at a time, next one accepted the cycle after the result is
//   loaded; a read scans the key table, then reads the memory; a held result stalls the load
// reset: rst_n async low clears valid bits, config and control; memories hold garbage
module transaction_latency_histogram
    import tlh_pkg::*;
#(
    parameter int PENDING_DEPTH = 256,
    parameter int HIST_KEYS     = 16,
    parameter int SLOTS         = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_ns, tid, reg_id, method, tl_word_first, tl_word_after_string,
    // latency_first, latency_after_string, read_index, zero pad
    input  logic [255:0] s_tdata,
    // cmd, hist_select
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // e2e_bucket, fw_recorded, fw_bucket, read_value, zero pad
    output logic [79:0]  m_tdata,
    // status
    output logic [2:0]   m_tuser,
    // configuration writes: 0 ms_mode, 1 reg_filter
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    tlh_cmd_t cmd;
    tlh_sts_t sts;

    // sequencer: one transaction in flight, result register frees the input side
    tlh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, histogram memories, divider, log2 unit and result register
    tlh_dp #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .HIST_KEYS     (HIST_KEYS),
        .SLOTS         (SLOTS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== tb/transaction_latency_histogram_checker.sv =====
// transaction_latency_histogram_checker: watches the input, result and config ports,
// predicts each result and compares it field by field; depends on tlh_pkg
`timescale 1ns / 100ps
module transaction_latency_histogram_checker
    import tlh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [79:0]  m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    output int           errors,
    output int           awaited
);
    localparam int PEND = 256;
    localparam int KEYS = 16;
    localparam int NBIN = 32;

    typedef struct {
        logic [2:0]  status;
        logic [4:0]  e2e_bucket;
        logic        fw_recorded;
        logic [4:0]  fw_bucket;
        logic [63:0] read_value;
    } outcome_t;

    outcome_t    outcome_q[$];
    logic        ms_mode;
    logic [15:0] reg_filter;
    logic        pend_v[PEND];
    logic [63:0] pend_tid[PEND];
    logic [63:0] pend_ts[PEND];
    logic        key_v[KEYS];
    logic [16:0] key_val[KEYS];
    logic [31:0] e2e_bin[KEYS][NBIN];
    logic [31:0] fw_bin[KEYS][NBIN];
    logic [63:0] e2e_sum[KEYS], e2e_cnt[KEYS], fw_sum[KEYS], fw_cnt[KEYS];

    assign awaited = outcome_q.size();

    // floor log2, zero and one land in bucket 0, capped at the last bucket
    function automatic logic [4:0] log2_bucket(logic [63:0] v);
        int b;
        b = 0;
        for (int i = 1; i < 64; i++)
            if (v[i]) b = i;
        return (b > NBIN - 1) ? 5'(NBIN - 1) : 5'(b);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_mode = 1'b0;
            reg_filter = '0;
            foreach (pend_v[i]) pend_v[i] = 1'b0;
            foreach (key_v[i]) key_v[i] = 1'b0;
            outcome_q.delete();
            errors = 0;
        end
        else
        begin
            outcome_t    exp_r, got;
            logic [1:0]  cmd;
            logic        hsel, filt, wr, has_lat;
            logic [63:0] now, tid, delta, lat;
            logic [15:0] regid;
            logic [7:0]  meth;
            logic [15:0] tl1, tl2;
            logic [5:0]  idx;
            logic [16:0] key;
            int          p, k;

            if (cfg_we)
            begin
                if (cfg_index == REG_MS_MODE) ms_mode = cfg_wdata[0];
                else reg_filter = cfg_wdata;
            end

            // result side first: a result never belongs to the item accepted this edge
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser, m_tdata[4:0], m_tdata[5], m_tdata[10:6], m_tdata[74:11]};
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d", $time, got.status);
                    errors++;
                end
                else
                begin
                    exp_r = outcome_q.pop_front();
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status,
                                 got.status);
                        errors++;
                    end
                    if (got.e2e_bucket !== exp_r.e2e_bucket)
                    begin
                        $display("%0t: e2e_bucket exp %0d got %0d", $time,
                                 exp_r.e2e_bucket, got.e2e_bucket);
                        errors++;
                    end
                    if (got.fw_recorded !== exp_r.fw_recorded)
                    begin
                        $display("%0t: fw_recorded exp %0d got %0d", $time,
                                 exp_r.fw_recorded, got.fw_recorded);
                        errors++;
                    end
                    if (got.fw_bucket !== exp_r.fw_bucket)
                    begin
                        $display("%0t: fw_bucket exp %0d got %0d", $time,
                                 exp_r.fw_bucket, got.fw_bucket);
                        errors++;
                    end
                    if (got.read_value !== exp_r.read_value)
                    begin
                        $display("%0t: read_value exp %h got %h", $time,
                                 exp_r.read_value, got.read_value);
                        errors++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                cmd   = s_tuser[1:0];
                hsel  = s_tuser[2];
                now   = s_tdata[63:0];
                tid   = s_tdata[127:64];
                regid = s_tdata[143:128];
                meth  = s_tdata[151:144];
                tl1   = s_tdata[167:152];
                tl2   = s_tdata[183:168];
                idx   = s_tdata[253:248];
                filt  = (reg_filter != 0) && (regid != reg_filter);
                wr    = (meth[6:0] == METHOD_WRITE);
                key   = {regid, wr};
                exp_r = '{ST_RECORDED, 5'd0, 1'b0, 5'd0, 64'd0};
                p = -1;
                k = -1;
                if (!filt && cmd != CMD_READ)
                    for (int i = 0; i < PEND; i++)
                        if (p < 0 && pend_v[i] && pend_tid[i] == tid) p = i;
                for (int i = 0; i < KEYS; i++)
                    if (k < 0 && key_v[i] && key_val[i] == key) k = i;

                case (cmd)
                    CMD_TX:
                    begin
                        if (filt) exp_r.status = ST_FILTERED;
                        else
                        begin
                            for (int i = 0; i < PEND; i++)
                                if (p < 0 && !pend_v[i]) p = i;
                            if (p < 0) exp_r.status = ST_FULL;
                            else
                            begin
                                pend_v[p] = 1'b1;
                                pend_tid[p] = tid;
                                pend_ts[p] = now;
                            end
                        end
                    end
                    CMD_RX:
                    begin
                        if (filt) exp_r.status = ST_FILTERED;
                        else if (p < 0) exp_r.status = ST_NO_MATCH;
                        else
                        begin
                            delta = now - pend_ts[p];
                            pend_v[p] = 1'b0;
                            if (delta[63]) exp_r.status = ST_NEGATIVE;
                            else
                            begin
                                // new key: take the first free slot and clear its bins
                                if (k < 0)
                                begin
                                    for (int i = 0; i < KEYS; i++)
                                        if (k < 0 && !key_v[i]) k = i;
                                    if (k >= 0)
                                    begin
                                        key_v[k] = 1'b1;
                                        key_val[k] = key;
                                        for (int j = 0; j < NBIN; j++)
                                        begin
                                            e2e_bin[k][j] = '0;
                                            fw_bin[k][j] = '0;
                                        end
                                        e2e_sum[k] = '0;
                                        e2e_cnt[k] = '0;
                                        fw_sum[k] = '0;
                                        fw_cnt[k] = '0;
                                    end
                                end
                                if (k < 0) exp_r.status = ST_FULL;
                                else
                                begin
                                    has_lat = 1'b0;
                                    lat = '0;
                                    if (tl1[15:11] == TLV_STRING)
                                    begin
                                        if (tl2[15:11] == TLV_LATENCY)
                                        begin
                                            has_lat = 1'b1;
                                            lat = {32'd0, s_tdata[247:216]};
                                        end
                                    end
                                    else if (tl1[15:11] == TLV_LATENCY)
                                    begin
                                        has_lat = 1'b1;
                                        lat = {32'd0, s_tdata[215:184]};
                                    end
                                    delta = ms_mode ? delta / 64'd1000000 : delta / 64'd1000;
                                    exp_r.e2e_bucket = log2_bucket(delta);
                                    e2e_bin[k][exp_r.e2e_bucket]++;
                                    e2e_sum[k] += delta;
                                    e2e_cnt[k]++;
                                    if (has_lat)
                                    begin
                                        exp_r.fw_recorded = 1'b1;
                                        exp_r.fw_bucket = log2_bucket(lat);
                                        fw_bin[k][exp_r.fw_bucket]++;
                                        fw_sum[k] += lat;
                                        fw_cnt[k]++;
                                    end
                                end
                            end
                        end
                    end
                    CMD_READ:
                    begin
                        exp_r.status = ST_READ_MISS;
                        if (k >= 0 && idx <= NBIN + 1)
                        begin
                            exp_r.status = ST_READ_OK;
                            if (idx < NBIN)
                                exp_r.read_value = hsel ? fw_bin[k][idx] : e2e_bin[k][idx];
                            else if (idx == NBIN)
                                exp_r.read_value = hsel ? fw_sum[k] : e2e_sum[k];
                            else
                                exp_r.read_value = hsel ? fw_cnt[k] : e2e_cnt[k];
                        end
                    end
                    default: ;
                endcase
                if (cmd != CMD_NONE) outcome_q.push_back(exp_r);
            end
        end
    end
endmodule

// ===== tb/transaction_latency_histogram_test.sv =====
// transaction_latency_histogram_test: stimulus and verdict for the latency histogram;
// depends on tlh_pkg, transaction_latency_histogram and the checker module
`timescale 1ns / 100ps
module transaction_latency_histogram_test;
    import tlh_pkg::*;

    // quiet time added once every awaited result has come out
    localparam int QUIET_CYCLES = 700;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;
    int           errors;
    int           awaited;
    logic         idle_en = 1'b1;
    int           stall_left = 0;

    // transmits still open on the stimulus side, used to build matching receives
    typedef struct {
        logic [63:0] tid;
        logic [63:0] ts;
        logic [15:0] regid;
        logic [7:0]  meth;
    } open_tx_t;
    open_tx_t     open_q[$];
    logic [63:0]  clock_ns;
    logic [15:0]  reg_pool[4] = '{16'h0001, 16'hABCD, 16'h8000, 16'hFFFF};

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    transaction_latency_histogram DUT (.*);

    transaction_latency_histogram_checker u_checker (.*);

    // result side back-pressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #30ms;
        $display("transaction_latency_histogram_test: done, errors");
        $finish;
    end

    // one transaction into the block; valid stays up between back-to-back sends
    task automatic send(logic [1:0] cmd, logic [63:0] ts, logic [63:0] tid,
                        logic [15:0] regid, logic [7:0] meth, logic [15:0] tl1,
                        logic [15:0] tl2, logic [31:0] lat1, logic [31:0] lat2,
                        logic hsel, logic [5:0] idx);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, lat2, lat1, tl2, tl1, meth, regid, tid, ts};
        s_tuser  <= {hsel, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random value of random magnitude, so every bucket gets hit
    function automatic logic [63:0] rand_mag(int top);
        return rand64() >> (63 - $urandom_range(0, top));
    endfunction

    function automatic logic [15:0] pick_reg();
        return ($urandom_range(0, 9) < 8) ? reg_pool[$urandom_range(0, 3)] : 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_method();
        case ($urandom_range(0, 3))
            0: return 8'h02;
            1: return 8'h82;
            default: return 8'($urandom);
        endcase
    endfunction

    // type-length word with the given type and random length bits
    function automatic logic [15:0] tlv(logic [4:0] ty);
        return {ty, 11'($urandom)};
    endfunction

    // random transaction, mostly a well-formed transmit/receive pairing
    task automatic random_item();
        open_tx_t    t;
        logic [15:0] tl1, tl2;
        logic [63:0] ts;
        int          sel, pos;
        sel = $urandom_range(0, 99);
        if (sel < 40 || (sel < 75 && open_q.size() == 0))
        begin
            t.tid   = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 500));
            clock_ns += rand_mag(40);
            t.ts    = ($urandom_range(0, 15) == 0) ? rand64() : clock_ns;
            t.regid = pick_reg();
            t.meth  = pick_method();
            if (open_q.size() < 300) open_q.push_back(t);
            send(CMD_TX, t.ts, t.tid, t.regid, t.meth, 16'($urandom), 16'($urandom),
                 $urandom, $urandom, 1'($urandom), 6'($urandom));
        end
        else if (sel < 75)
        begin
            pos = $urandom_range(0, open_q.size() - 1);
            t = open_q[pos];
            open_q.delete(pos);
            ts = ($urandom_range(0, 11) == 0) ? t.ts - rand_mag(30) - 1
                                               : t.ts + rand_mag($urandom_range(0, 1) ? 30 : 62);
            case ($urandom_range(0, 3))
                0: begin tl1 = tlv(TLV_LATENCY); tl2 = 16'($urandom); end
                1: begin tl1 = tlv(TLV_STRING); tl2 = tlv(TLV_LATENCY); end
                2: begin tl1 = tlv(TLV_STRING); tl2 = 16'($urandom); end
                default: begin tl1 = 16'($urandom); tl2 = 16'($urandom); end
            endcase
            send(CMD_RX, ts, t.tid, t.regid, t.meth, tl1, tl2, 32'(rand_mag(31)),
                 32'(rand_mag(31)), 1'($urandom), 6'($urandom));
        end
        else if (sel < 83)
            send(CMD_RX, rand64(), rand64(), pick_reg(), pick_method(), 16'($urandom),
                 16'($urandom), $urandom, $urandom, 1'($urandom), 6'($urandom));
        else if (sel < 98)
            send(CMD_READ, rand64(), rand64(), pick_reg(), pick_method(), 16'($urandom),
                 16'($urandom), $urandom, $urandom, 1'($urandom),
                 ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 33)));
        else
            send(CMD_NONE, rand64(), rand64(), 16'($urandom), 8'($urandom), 16'($urandom),
                 16'($urandom), $urandom, $urandom, 1'($urandom), 6'($urandom));
    endtask

    initial
    begin
        clock_ns = 64'd1_000_000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_MS_MODE, 16'd0);
        write_reg(REG_FILTER, 16'd0);

        // directed: zero delta, repeated transmit id, largest delta, negative delta, no match, reads
        send(CMD_TX, 64'd5000, 64'd0, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_TX, 64'd6000, 64'd0, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_RX, 64'd6000, 64'd0, 16'h0001, 8'h02, tlv(TLV_LATENCY), 0, 0, 0, 0, 0);
        send(CMD_TX, 64'd0, '1, 16'hFFFF, 8'h80, 0, 0, 0, 0, 0, 0);
        send(CMD_RX, 64'h7FFF_FFFF_FFFF_FFFF, '1, 16'hFFFF, 8'h80, tlv(TLV_STRING),
             tlv(TLV_LATENCY), 0, '1, 0, 0);
        send(CMD_TX, 64'd1000, 64'd5, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_RX, 64'd999, 64'd5, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_RX, 64'd999, 64'd12345, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_TX, 64'd0, 64'd7, 16'h0001, 8'h02, 0, 0, 0, 0, 0, 0);
        send(CMD_RX, 64'd1999, 64'd7, 16'h0001, 8'h02, tlv(TLV_STRING), tlv(5'd3),
             '1, '1, 0, 0);
        send(CMD_NONE, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, '1);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b0, 6'd0);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b0, 6'd31);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b0, 6'd32);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b0, 6'd33);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b1, 6'd0);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b1, 6'd32);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b1, 6'd33);
        send(CMD_READ, 0, 0, 16'hFFFF, 8'h80, 0, 0, 0, 0, 1'b0, 6'd31);
        send(CMD_READ, 0, 0, 16'hFFFF, 8'h80, 0, 0, 0, 0, 1'b1, 6'd31);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b0, 6'd34);
        send(CMD_READ, 0, 0, 16'h0001, 8'h02, 0, 0, 0, 0, 1'b1, 6'd63);
        send(CMD_READ, 0, 0, 16'h1234, 8'h02, 0, 0, 0, 0, 1'b0, 6'd0);
        drain();

        // microsecond scale, no filter
        repeat (400) random_item();
        drain();

        // millisecond scale, trace one pooled register only
        write_reg(REG_MS_MODE, 16'd1);
        write_reg(REG_FILTER, 16'hABCD);
        repeat (200) random_item();
        drain();

        // filter on the top register id
        write_reg(REG_FILTER, 16'hFFFF);
        repeat (60) random_item();
        drain();

        // fill the pending table past capacity, then close every entry
        write_reg(REG_MS_MODE, 16'd0);
        write_reg(REG_FILTER, 16'd0);
        open_q.delete();
        for (int i = 0; i < 260; i++)
            send(CMD_TX, clock_ns + i, 64'h1_0000_0000 + i, 16'h8000, 8'h02,
                 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 260; i++)
            send(CMD_RX, clock_ns + 64'(i) * 4096, 64'h1_0000_0000 + i, 16'h8000, 8'h02,
                 tlv(TLV_LATENCY), 0, $urandom, 0, 0, 0);
        drain();

        // closing stretch with no idling on either side
        idle_en <= 1'b0;
        repeat (300) random_item();
        drain();

        if (errors == 0)
            $display("transaction_latency_histogram_test: done, clean");
        else
            $display("transaction_latency_histogram_test: done, errors");
        $finish;
    end
endmodule
